>>> hw/rtl/msc_pkg.sv
package msc_pkg;

    localparam int RAW_W      = 12;
    localparam int IN_W       = RAW_W + 1;
    localparam int FRAC_W     = 8;
    localparam int PCT_W      = 7 + FRAC_W;
    localparam int PCT_MAX    = 100 << FRAC_W;
    localparam int ALPHA_W    = FRAC_W + 1;
    localparam int ALPHA_ONE  = 1 << FRAC_W;
    localparam int CNT_W      = 8;
    localparam int CNT_MAX    = (1 << CNT_W) - 1;
    localparam int NUM_W      = RAW_W + PCT_W;
    localparam int DIV_CNT_W  = $clog2(PCT_W);
    localparam int PROD_W     = ALPHA_W + PCT_W;
    localparam int APB_AW     = 5;
    localparam int APB_DW     = 32;

    localparam logic [RAW_W-1:0]   RST_RAW_DRY    = RAW_W'(2800);
    localparam logic [RAW_W-1:0]   RST_RAW_WET    = RAW_W'(1200);
    localparam logic [RAW_W-1:0]   RST_MIN_SPAN   = RAW_W'(200);
    localparam logic [RAW_W-1:0]   RST_VALID_LOW  = RAW_W'(100);
    localparam logic [RAW_W-1:0]   RST_VALID_HIGH = RAW_W'(4000);
    localparam logic [ALPHA_W-1:0] RST_EMA_ALPHA  = ALPHA_W'(77);
    localparam logic [CNT_W-1:0]   RST_FAULT_TH   = CNT_W'(3);
    localparam logic [CNT_W-1:0]   RST_RECOVER_TH = CNT_W'(3);

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_DRV   = 3'd1,
        ST_RANGE = 3'd2,
        ST_CAL   = 3'd3,
        ST_FAULT = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        REG_RAW_DRY    = 3'd0,
        REG_RAW_WET    = 3'd1,
        REG_MIN_SPAN   = 3'd2,
        REG_VALID_LOW  = 3'd3,
        REG_VALID_HIGH = 3'd4,
        REG_EMA_ALPHA  = 3'd5,
        REG_FAULT_TH   = 3'd6,
        REG_RECOVER_TH = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_DIV,
        S_EMA_MUL,
        S_EMA_SUM,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PM_ZERO,
        PM_SAT,
        PM_DIV
    } t_pct_mode;

    typedef struct packed {
        logic [RAW_W-1:0]   raw_dry;
        logic [RAW_W-1:0]   raw_wet;
        logic [RAW_W-1:0]   min_span;
        logic [RAW_W-1:0]   valid_low;
        logic [RAW_W-1:0]   valid_high;
        logic [ALPHA_W-1:0] ema_alpha;
        logic [CNT_W-1:0]   fault_threshold;
        logic [CNT_W-1:0]   recovery_threshold;
    } t_cfg;

    typedef struct packed {
        logic setup;
        logic div_step;
        logic ema_mul;
        logic ema_sum;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic invalid;
        logic need_div;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

>>> hw/rtl/msc_regs.sv
module msc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [msc_pkg::APB_AW-1:0]   paddr,
    input  logic [msc_pkg::APB_DW-1:0]   pwdata,
    output logic [msc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output msc_pkg::t_cfg                o_cfg
);

    msc_pkg::t_cfg    r_cfg;
    msc_pkg::t_reg_idx w_idx;

    assign w_idx  = msc_pkg::t_reg_idx'(paddr[msc_pkg::APB_AW-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raw_dry            <= msc_pkg::RST_RAW_DRY;
            r_cfg.raw_wet            <= msc_pkg::RST_RAW_WET;
            r_cfg.min_span           <= msc_pkg::RST_MIN_SPAN;
            r_cfg.valid_low          <= msc_pkg::RST_VALID_LOW;
            r_cfg.valid_high         <= msc_pkg::RST_VALID_HIGH;
            r_cfg.ema_alpha          <= msc_pkg::RST_EMA_ALPHA;
            r_cfg.fault_threshold    <= msc_pkg::RST_FAULT_TH;
            r_cfg.recovery_threshold <= msc_pkg::RST_RECOVER_TH;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                msc_pkg::REG_RAW_DRY:    r_cfg.raw_dry <= pwdata[msc_pkg::RAW_W-1:0];
                msc_pkg::REG_RAW_WET:    r_cfg.raw_wet <= pwdata[msc_pkg::RAW_W-1:0];
                msc_pkg::REG_MIN_SPAN:   r_cfg.min_span <= pwdata[msc_pkg::RAW_W-1:0];
                msc_pkg::REG_VALID_LOW:  r_cfg.valid_low <= pwdata[msc_pkg::RAW_W-1:0];
                msc_pkg::REG_VALID_HIGH: r_cfg.valid_high <= pwdata[msc_pkg::RAW_W-1:0];
                msc_pkg::REG_EMA_ALPHA:  r_cfg.ema_alpha <= pwdata[msc_pkg::ALPHA_W-1:0];
                msc_pkg::REG_FAULT_TH:   r_cfg.fault_threshold <= pwdata[msc_pkg::CNT_W-1:0];
                msc_pkg::REG_RECOVER_TH: r_cfg.recovery_threshold <= pwdata[msc_pkg::CNT_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            msc_pkg::REG_RAW_DRY:    prdata = msc_pkg::APB_DW'(r_cfg.raw_dry);
            msc_pkg::REG_RAW_WET:    prdata = msc_pkg::APB_DW'(r_cfg.raw_wet);
            msc_pkg::REG_MIN_SPAN:   prdata = msc_pkg::APB_DW'(r_cfg.min_span);
            msc_pkg::REG_VALID_LOW:  prdata = msc_pkg::APB_DW'(r_cfg.valid_low);
            msc_pkg::REG_VALID_HIGH: prdata = msc_pkg::APB_DW'(r_cfg.valid_high);
            msc_pkg::REG_EMA_ALPHA:  prdata = msc_pkg::APB_DW'(r_cfg.ema_alpha);
            msc_pkg::REG_FAULT_TH:   prdata = msc_pkg::APB_DW'(r_cfg.fault_threshold);
            msc_pkg::REG_RECOVER_TH: prdata = msc_pkg::APB_DW'(r_cfg.recovery_threshold);
        endcase
    end

endmodule

>>> hw/rtl/msc_ctrl.sv
module msc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  msc_pkg::t_sts i_sts,
    output msc_pkg::t_cmd o_cmd
);

    msc_pkg::t_state r_state;
    msc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            msc_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = msc_pkg::S_CALC;
                end
            end
            msc_pkg::S_CALC: begin
                o_cmd.setup = 1'b1;
                if (i_sts.invalid) begin
                    n_state = msc_pkg::S_DONE;
                end else if (i_sts.need_div) begin
                    n_state = msc_pkg::S_DIV;
                end else begin
                    n_state = msc_pkg::S_EMA_MUL;
                end
            end
            msc_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = msc_pkg::S_EMA_MUL;
                end
            end
            msc_pkg::S_EMA_MUL: begin
                o_cmd.ema_mul = 1'b1;
                n_state       = msc_pkg::S_EMA_SUM;
            end
            msc_pkg::S_EMA_SUM: begin
                o_cmd.ema_sum = 1'b1;
                n_state       = msc_pkg::S_DONE;
            end
            msc_pkg::S_DONE: begin
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = msc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = msc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/msc_dp.sv
module msc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic signed [msc_pkg::IN_W-1:0]   i_raw,
    input  msc_pkg::t_cfg                     i_cfg,
    input  msc_pkg::t_cmd                     i_cmd,
    output msc_pkg::t_sts                     o_sts,
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic signed [msc_pkg::IN_W-1:0]   o_raw_echo,
    output logic                              o_valid_res,
    output logic [2:0]                        o_status,
    output logic [msc_pkg::PCT_W-1:0]         o_raw_percent,
    output logic [msc_pkg::PCT_W-1:0]         o_percent
);

    localparam int RW = msc_pkg::RAW_W;
    localparam int PW = msc_pkg::PCT_W;
    localparam int NW = msc_pkg::NUM_W;
    localparam int CW = msc_pkg::CNT_W;
    localparam int AW = msc_pkg::ALPHA_W;
    localparam int QW = msc_pkg::PROD_W;
    localparam int FW = msc_pkg::FRAC_W;
    localparam int DW = msc_pkg::DIV_CNT_W;

    // sample and per-item working registers
    logic signed [msc_pkg::IN_W-1:0] r_raw;
    msc_pkg::t_status                r_cls;
    msc_pkg::t_pct_mode              r_mode;
    logic [RW:0]                     r_rem;
    logic [PW-1:0]                   r_nlo;
    logic [PW-1:0]                   r_quo;
    logic [RW-1:0]                   r_div;
    logic [DW-1:0]                   r_dcnt;
    logic [QW-1:0]                   r_p1;
    logic [QW-1:0]                   r_p2;

    // filter and run state
    logic                            r_seeded;
    logic [PW-1:0]                   r_filt;
    logic [CW-1:0]                   r_irun;
    logic [CW-1:0]                   r_vrun;

    // result register
    logic                            r_ovalid;
    logic signed [msc_pkg::IN_W-1:0] r_o_raw;
    logic                            r_o_vres;
    msc_pkg::t_status                r_o_status;
    logic [PW-1:0]                   r_o_rawpct;
    logic [PW-1:0]                   r_o_pct;

    logic signed [RW:0]              w_span;
    logic signed [RW:0]              w_diff;
    logic                            w_bad_cal;
    logic                            w_oor;
    msc_pkg::t_status                w_cls;
    msc_pkg::t_pct_mode              w_mode;
    logic [NW-1:0]                   w_num;
    logic [RW:0]                     w_trial;
    logic                            w_ge;
    logic [PW-1:0]                   w_rawpct;
    logic [AW-1:0]                   w_alpha;
    logic [QW:0]                     w_sum;
    logic [CW-1:0]                   w_irun_inc;
    logic [CW-1:0]                   w_vrun_inc;
    logic                            w_faulted;
    logic                            w_out_free;

    // classification
    assign w_span    = $signed({1'b0, i_cfg.raw_dry}) - $signed({1'b0, i_cfg.raw_wet});
    assign w_diff    = $signed({1'b0, i_cfg.raw_dry}) - r_raw;
    assign w_bad_cal = w_span < $signed({1'b0, i_cfg.min_span});
    assign w_oor     = (r_raw[RW-1:0] < i_cfg.valid_low) || (r_raw[RW-1:0] > i_cfg.valid_high);

    always_comb begin
        priority if (w_bad_cal) begin
            w_cls = msc_pkg::ST_CAL;
        end else if (r_raw[msc_pkg::IN_W-1]) begin
            w_cls = msc_pkg::ST_DRV;
        end else if (w_oor) begin
            w_cls = msc_pkg::ST_RANGE;
        end else begin
            w_cls = msc_pkg::ST_OK;
        end
    end

    always_comb begin
        priority if (w_span <= 0 || w_diff <= 0) begin
            w_mode = msc_pkg::PM_ZERO;
        end else if (w_diff >= w_span) begin
            w_mode = msc_pkg::PM_SAT;
        end else begin
            w_mode = msc_pkg::PM_DIV;
        end
    end

    assign w_num   = NW'(w_diff[RW-1:0]) * NW'(msc_pkg::PCT_MAX);
    assign w_trial = {r_rem[RW-1:0], r_nlo[PW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};

    always_comb begin
        unique case (r_mode)
            msc_pkg::PM_ZERO: w_rawpct = '0;
            msc_pkg::PM_SAT:  w_rawpct = PW'(msc_pkg::PCT_MAX);
            msc_pkg::PM_DIV:  w_rawpct = r_quo;
            default:          w_rawpct = '0;
        endcase
    end

    assign w_alpha = (i_cfg.ema_alpha > AW'(msc_pkg::ALPHA_ONE)) ?
                     AW'(msc_pkg::ALPHA_ONE) : i_cfg.ema_alpha;
    assign w_sum   = {1'b0, r_p1} + {1'b0, r_p2};

    assign w_irun_inc = (r_irun == CW'(msc_pkg::CNT_MAX)) ? r_irun : r_irun + 1'b1;
    assign w_vrun_inc = (r_vrun == CW'(msc_pkg::CNT_MAX)) ? r_vrun : r_vrun + 1'b1;
    assign w_faulted  = r_irun >= i_cfg.fault_threshold;
    assign w_out_free = !r_ovalid || i_ready;

    assign o_sts.invalid  = w_cls != msc_pkg::ST_OK;
    assign o_sts.need_div = w_mode == msc_pkg::PM_DIV;
    assign o_sts.div_last = r_dcnt == DW'(PW - 1);
    assign o_sts.out_free = w_out_free;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_raw <= i_raw;
        end
        if (i_cmd.setup) begin
            r_cls  <= w_cls;
            r_mode <= w_mode;
            r_rem  <= {1'b0, w_num[NW-1:PW]};
            r_nlo  <= w_num[PW-1:0];
            r_quo  <= '0;
            r_div  <= w_span[RW-1:0];
            r_dcnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_trial - {1'b0, r_div} : w_trial;
            r_nlo  <= {r_nlo[PW-2:0], 1'b0};
            r_quo  <= {r_quo[PW-2:0], w_ge};
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.ema_mul) begin
            r_p1 <= QW'(w_alpha) * QW'(w_rawpct);
            r_p2 <= QW'(AW'(msc_pkg::ALPHA_ONE) - w_alpha) * QW'(r_filt);
        end
        if (i_cmd.commit) begin
            r_o_raw <= r_raw;
            if (r_cls != msc_pkg::ST_OK) begin
                r_o_vres   <= 1'b0;
                r_o_status <= (w_irun_inc >= i_cfg.fault_threshold) ? msc_pkg::ST_FAULT : r_cls;
                r_o_rawpct <= r_filt;
                r_o_pct    <= r_filt;
            end else begin
                r_o_rawpct <= w_rawpct;
                r_o_pct    <= r_filt;
                if (w_faulted && w_vrun_inc < i_cfg.recovery_threshold) begin
                    r_o_vres   <= 1'b0;
                    r_o_status <= msc_pkg::ST_FAULT;
                end else begin
                    r_o_vres   <= 1'b1;
                    r_o_status <= msc_pkg::ST_OK;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_filt   <= '0;
            r_irun   <= '0;
            r_vrun   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.ema_sum) begin
                r_seeded <= 1'b1;
                r_filt   <= r_seeded ? w_sum[FW +: PW] : w_rawpct;
            end
            if (i_cmd.commit) begin
                if (r_cls != msc_pkg::ST_OK) begin
                    r_vrun <= '0;
                    r_irun <= w_irun_inc;
                end else begin
                    r_vrun <= w_vrun_inc;
                    if (!(w_faulted && w_vrun_inc < i_cfg.recovery_threshold)) begin
                        r_irun <= '0;
                    end
                end
            end
            if (i_cmd.commit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_ovalid;
    assign o_raw_echo    = r_o_raw;
    assign o_valid_res   = r_o_vres;
    assign o_status      = r_o_status;
    assign o_raw_percent = r_o_rawpct;
    assign o_percent     = r_o_pct;

endmodule

>>> hw/rtl/moisture_sample_conditioner_unit.sv
// from accept, an invalid sample passes the calc state and then the done state; a valid sample
// whose percent is zero or saturated passes calc, EMA multiply, EMA sum and done, and one that
// needs the 15-step divide by the span also passes the divide state after calc;
// a new item is taken only in idle; the result register lets the next item be accepted while
// a result waits, and one finishing while that register is still held waits in done until it frees
// synchronous active-low reset restores default calibration and clears filter and fault runs
module moisture_sample_conditioner_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [msc_pkg::IN_W-1:0]    i_raw,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [msc_pkg::IN_W-1:0]    o_raw_echo,
    output logic                               o_valid_res,
    output logic [2:0]                         o_status,
    output logic [msc_pkg::PCT_W-1:0]          o_raw_percent,
    output logic [msc_pkg::PCT_W-1:0]          o_percent,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [msc_pkg::APB_AW-1:0]         paddr,
    input  logic [msc_pkg::APB_DW-1:0]         pwdata,
    output logic [msc_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);

    msc_pkg::t_cfg w_cfg;
    msc_pkg::t_cmd w_cmd;
    msc_pkg::t_sts w_sts;

    msc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    msc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    msc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (i_valid && o_ready),
        .i_raw         (i_raw),
        .i_cfg         (w_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_ready       (i_ready),
        .o_valid       (o_valid),
        .o_raw_echo    (o_raw_echo),
        .o_valid_res   (o_valid_res),
        .o_status      (o_status),
        .o_raw_percent (o_raw_percent),
        .o_percent     (o_percent)
    );

endmodule
